/* src/bpfa_pkg.sv */
// shared constants, codes and control types of the bitmap page frame allocator
package bpfa_pkg;

    localparam int unsigned BITMAP_BYTES = 4096;
    localparam int unsigned ADDR_W       = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int unsigned CNT_W        = $clog2(BITMAP_BYTES + 1);
    localparam int unsigned TOTAL_FRAMES = BITMAP_BYTES * 8;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned REQ_W    = 2;
    localparam int unsigned FRAME_W  = 15;
    localparam int unsigned STATUS_W = 2;

    localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hFF;

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;
    localparam logic [REQ_W-1:0] REQ_INIT  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;     // capture the request, set up scan and result
        logic scan_run;   // byte scan for a clear bit
        logic look_rd;    // read the byte of the requested frame
        logic look_chk;   // act on that byte for free or query
        logic sweep_run;  // write every byte in order
        logic sweep_init; // sweep writes the reserved pattern instead of zero
        logic load_out;   // move the result into the output register
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic scan_found;
        logic scan_none;
        logic sweep_last;
        logic out_free;
    } t_sts;

    // index of the lowest clear bit, seven when bits zero to six are all set
    function automatic logic [2:0] lowest_clear(input logic [BYTE_W-1:0] b);
        logic [2:0] idx;
        idx = 3'd7;
        for (int k = 6; k >= 0; k--) begin
            if (!b[k]) begin
                idx = 3'(k);
            end
        end
        return idx;
    endfunction

endpackage

/* src/bpfa_if.sv */
// valid/ready channel interfaces for requests and responses
interface bpfa_req_if;
    logic                               valid;
    logic                               ready;
    logic [bpfa_pkg::REQ_W-1:0]         req_type;
    logic [bpfa_pkg::FRAME_W-1:0]       frame_number;

    modport source (output valid, output req_type, output frame_number, input ready);
    modport sink   (input valid, input req_type, input frame_number, output ready);
endinterface

interface bpfa_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [bpfa_pkg::FRAME_W-1:0]       result_frame;
    logic [bpfa_pkg::STATUS_W-1:0]      status;
    logic                               is_allocated;

    modport source (output valid, output result_frame, output status, output is_allocated,
                    input ready);
    modport sink   (input valid, input result_frame, input status, input is_allocated,
                    output ready);
endinterface

/* src/bpfa_ctrl.sv */
// controller state machine sequencing clear, scan, lookup, sweep and response
module bpfa_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [bpfa_pkg::REQ_W-1:0]  i_req_type,
    input  bpfa_pkg::t_sts              i_sts,
    output logic                        o_in_ready,
    output bpfa_pkg::t_cmd              o_cmd
);

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_SCAN     = 3'd2;
    localparam logic [2:0] ST_LOOK_RD  = 3'd3;
    localparam logic [2:0] ST_LOOK_CHK = 3'd4;
    localparam logic [2:0] ST_SWEEP    = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.sweep_run = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_req_type)
                        bpfa_pkg::REQ_ALLOC: n_state = ST_SCAN;
                        bpfa_pkg::REQ_FREE:  n_state = ST_LOOK_RD;
                        bpfa_pkg::REQ_QUERY: n_state = ST_LOOK_RD;
                        default:             n_state = ST_SWEEP;
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_found || i_sts.scan_none) begin
                    n_state = ST_DONE;
                end
            end
            ST_LOOK_RD: begin
                o_cmd.look_rd = 1'b1;
                n_state       = ST_LOOK_CHK;
            end
            ST_LOOK_CHK: begin
                o_cmd.look_chk = 1'b1;
                n_state        = ST_DONE;
            end
            ST_SWEEP: begin
                o_cmd.sweep_run  = 1'b1;
                o_cmd.sweep_init = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* src/bpfa_datapath.sv */
// bitmap memory, search cursor, scan counters and response register
module bpfa_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bpfa_pkg::t_cmd                  i_cmd,
    output bpfa_pkg::t_sts                  o_sts,
    input  logic [bpfa_pkg::REQ_W-1:0]      i_req_type,
    input  logic [bpfa_pkg::FRAME_W-1:0]    i_frame_number,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [bpfa_pkg::FRAME_W-1:0]    o_result_frame,
    output logic [bpfa_pkg::STATUS_W-1:0]   o_status,
    output logic                            o_is_allocated
);

    localparam int unsigned AW = bpfa_pkg::ADDR_W;
    localparam int unsigned CW = bpfa_pkg::CNT_W;
    localparam int unsigned BW = bpfa_pkg::BYTE_W;

    logic [BW-1:0] r_mem [bpfa_pkg::BITMAP_BYTES];

    logic [AW-1:0]                     r_cursor;
    logic [AW-1:0]                     r_scan_addr;
    logic [AW-1:0]                     r_chk_addr;
    logic                              r_chk_vld;
    logic [CW-1:0]                     r_cnt;
    logic [AW-1:0]                     r_sweep_addr;
    logic [BW-1:0]                     r_rd_data;
    logic [bpfa_pkg::REQ_W-1:0]        r_req_type;
    logic [bpfa_pkg::FRAME_W-1:0]      r_frame;
    logic [bpfa_pkg::FRAME_W-1:0]      r_res_frame;
    logic [bpfa_pkg::STATUS_W-1:0]     r_res_status;
    logic                              r_res_alloc;
    logic                              r_out_valid;
    logic [bpfa_pkg::FRAME_W-1:0]      r_out_frame;
    logic [bpfa_pkg::STATUS_W-1:0]     r_out_status;
    logic                              r_out_alloc;

    logic [31:0]   frame_ext;
    logic          in_range;
    logic [31:0]   last_ext;
    logic [AW-1:0] frame_byte;
    logic [AW-1:0] last_byte;
    logic [2:0]    last_bit;
    logic [8:0]    partial_mask;
    logic [BW-1:0] sweep_byte;
    logic          frame_bit;
    logic [2:0]    low_idx;
    logic          scan_issue;
    logic          scan_found;
    logic          cnt_full;
    logic          sweep_last;
    logic          free_ok;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [BW-1:0] wr_data;
    logic [AW-1:0] n_scan_addr;

    assign frame_ext    = 32'(r_frame);
    assign in_range     = frame_ext < bpfa_pkg::TOTAL_FRAMES;
    assign last_ext     = in_range ? frame_ext : (bpfa_pkg::TOTAL_FRAMES - 1);
    assign frame_byte   = AW'(frame_ext >> 3);
    assign last_byte    = AW'(last_ext >> 3);
    assign last_bit     = last_ext[2:0];
    assign partial_mask = (9'd2 << last_bit) - 9'd1;
    assign frame_bit    = r_rd_data[r_frame[2:0]];
    assign low_idx      = bpfa_pkg::lowest_clear(r_rd_data);

    // reserved pattern: full bytes below the last reserved byte, partial at it, zero above
    always_comb begin
        if (r_sweep_addr < last_byte) begin
            sweep_byte = bpfa_pkg::FULL_BYTE;
        end else if (r_sweep_addr == last_byte) begin
            sweep_byte = partial_mask[BW-1:0];
        end else begin
            sweep_byte = '0;
        end
    end

    assign cnt_full    = (r_cnt == CW'(bpfa_pkg::BITMAP_BYTES));
    assign scan_issue  = i_cmd.scan_run && !cnt_full;
    assign scan_found  = i_cmd.scan_run && r_chk_vld && (r_rd_data != bpfa_pkg::FULL_BYTE);
    assign sweep_last  = i_cmd.sweep_run && (r_sweep_addr == AW'(bpfa_pkg::BITMAP_BYTES - 1));
    assign free_ok     = i_cmd.look_chk && (r_req_type == bpfa_pkg::REQ_FREE)
                         && in_range && frame_bit;
    assign n_scan_addr = (r_scan_addr == AW'(bpfa_pkg::BITMAP_BYTES - 1)) ? '0
                         : r_scan_addr + AW'(1);

    assign o_sts.scan_found = scan_found;
    assign o_sts.scan_none  = i_cmd.scan_run && cnt_full && r_chk_vld
                              && (r_rd_data == bpfa_pkg::FULL_BYTE);
    assign o_sts.sweep_last = sweep_last;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign rd_addr = i_cmd.scan_run ? r_scan_addr : frame_byte;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_chk_addr;
        wr_data = r_rd_data;
        if (i_cmd.sweep_run) begin
            wr_en   = 1'b1;
            wr_addr = r_sweep_addr;
            wr_data = i_cmd.sweep_init ? sweep_byte : '0;
        end else if (scan_found) begin
            wr_en   = 1'b1;
            wr_addr = r_chk_addr;
            wr_data = r_rd_data | (BW'(1) << low_idx);
        end else if (free_ok) begin
            wr_en   = 1'b1;
            wr_addr = frame_byte;
            wr_data = r_rd_data & ~(BW'(1) << r_frame[2:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor     <= '0;
            r_sweep_addr <= '0;
            r_chk_vld    <= 1'b0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_cnt     <= '0;
                r_chk_vld <= 1'b0;
            end else if (i_cmd.scan_run) begin
                r_chk_vld <= scan_issue;
                if (scan_issue) begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end
            if (i_cmd.sweep_run) begin
                r_sweep_addr <= sweep_last ? '0 : r_sweep_addr + AW'(1);
            end
            if (scan_found) begin
                r_cursor <= r_chk_addr;
            end else if (free_ok) begin
                r_cursor <= frame_byte;
            end else if (sweep_last && i_cmd.sweep_init) begin
                r_cursor <= last_byte;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req_type   <= i_req_type;
            r_frame      <= i_frame_number;
            r_scan_addr  <= r_cursor;
            r_res_frame  <= '0;
            r_res_status <= bpfa_pkg::STATUS_OK;
            r_res_alloc  <= 1'b0;
        end else begin
            if (scan_issue) begin
                r_chk_addr  <= r_scan_addr;
                r_scan_addr <= n_scan_addr;
            end
            if (scan_found) begin
                r_res_frame <= bpfa_pkg::FRAME_W'({r_chk_addr, low_idx});
            end else if (o_sts.scan_none) begin
                r_res_status <= bpfa_pkg::STATUS_NO_FREE;
            end
            if (i_cmd.look_chk) begin
                if (r_req_type == bpfa_pkg::REQ_FREE) begin
                    r_res_status <= free_ok ? bpfa_pkg::STATUS_OK
                                            : bpfa_pkg::STATUS_NOT_ALLOC;
                end else begin
                    r_res_alloc <= in_range && frame_bit;
                end
            end
        end
        if (i_cmd.load_out) begin
            r_out_frame  <= r_res_frame;
            r_out_status <= r_res_status;
            r_out_alloc  <= r_res_alloc;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_frame = r_out_frame;
    assign o_status       = r_out_status;
    assign o_is_allocated = r_out_alloc;

endmodule

/* src/bitmap_page_frame_allocator_unit.sv */
// top level of the next-fit bitmap page frame allocator
//
//  channel  dir  handshake     payload
//  i_req    in   valid/ready   req_type[1:0], frame_number[14:0]
//  o_rsp    out  valid/ready   result_frame[14:0], status[1:0], is_allocated
//
// one request at a time; the bitmap memory (one byte per cycle) sets the timing
// free and query: the byte of the frame is read, then checked, then the result waits for the output register
// alloc: bytes are scanned one per cycle from the cursor until one has a clear bit or all are full
// init: the reserved pattern is written over every byte, one byte per cycle
// after reset a clearing pass writes zero to all BITMAP_BYTES (4096) bytes before i_req.ready rises
// a waiting response is held in the output register; the next request is still taken
module bitmap_page_frame_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bpfa_req_if.sink    i_req,
    bpfa_rsp_if.source  o_rsp
);

    bpfa_pkg::t_cmd w_cmd;
    bpfa_pkg::t_sts w_sts;
    logic           w_in_ready;

    bpfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_req_type (i_req.req_type),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    bpfa_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_req_type     (i_req.req_type),
        .i_frame_number (i_req.frame_number),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_result_frame (o_rsp.result_frame),
        .o_status       (o_rsp.status),
        .o_is_allocated (o_rsp.is_allocated)
    );

    assign i_req.ready = w_in_ready;

endmodule

/* src/bpfa_checker.sv */
// port-level checks of the allocator, bound to the top level
module bpfa_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_req_valid,
    input logic                             i_req_ready,
    input logic                             i_rsp_valid,
    input logic                             i_rsp_ready,
    input logic [bpfa_pkg::FRAME_W-1:0]     i_rsp_frame,
    input logic [bpfa_pkg::STATUS_W-1:0]    i_rsp_status,
    input logic                             i_rsp_alloc
);

    // one request in flight: ready drops right after a transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while another is in flight");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid)
        else $error("response dropped before transaction");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_status == bpfa_pkg::STATUS_OK
                         || i_rsp_status == bpfa_pkg::STATUS_NO_FREE
                         || i_rsp_status == bpfa_pkg::STATUS_NOT_ALLOC))
        else $error("undefined status code");

    // failed requests carry no frame and no query answer
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status != bpfa_pkg::STATUS_OK)
            |-> (i_rsp_frame == '0 && !i_rsp_alloc))
        else $error("failed response carries data");

    a_alloc_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_alloc) |-> (i_rsp_frame == '0))
        else $error("query answer with a frame number");

endmodule

bind bitmap_page_frame_allocator_unit bpfa_checker u_bpfa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_frame  (o_rsp.result_frame),
    .i_rsp_status (o_rsp.status),
    .i_rsp_alloc  (o_rsp.is_allocated)
);
